>>> rtl/arw_pkg.sv
// shared types and constants for the anti-replay window check
package arw_pkg;

	localparam int SEQ_W     = 64;
	localparam int WORD_W    = 64;
	localparam int VERDICT_W = 2;

	typedef enum logic [VERDICT_W-1:0] {
		VERDICT_ACCEPTED  = 2'd0,
		VERDICT_DUPLICATE = 2'd1,
		VERDICT_TOO_OLD   = 2'd2
	} verdict_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECIDE,
		S_SWEEP,
		S_DRAIN,
		S_CHECK,
		S_DONE
	} arw_state_t;

	typedef struct packed {
		logic load;
		logic init_all;
		logic sweep_init;
		logic take_top;
		logic sweep_rd;
		logic chk_mark;
	} arw_cmd_t;

	typedef struct packed {
		logic first;
		logic fwd;
		logic far;
		logic old;
		logic sweep_last;
		logic bit_set;
	} arw_sts_t;

endpackage

>>> rtl/arw_seq_if.sv
// sequence number channel
interface arw_seq_if import arw_pkg::*;;
	logic             valid;
	logic             ready;
	logic [SEQ_W-1:0] seq_number;

	modport source (output valid, output seq_number, input ready);
	modport sink (input valid, input seq_number, output ready);
endinterface

>>> rtl/arw_verdict_if.sv
// verdict channel
interface arw_verdict_if import arw_pkg::*;;
	logic                 valid;
	logic                 ready;
	logic [VERDICT_W-1:0] verdict;

	modport source (output valid, output verdict, input ready);
	modport sink (input valid, input verdict, output ready);
endinterface

>>> rtl/arw_dpath.sv
// datapath: highest sequence, circular seen bitmap memory and word sweep
module arw_dpath import arw_pkg::*; #(
	parameter int WINDOW_BITS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [SEQ_W-1:0] seq_number,
	input  arw_cmd_t         cmd,
	output arw_sts_t         sts
);

	localparam int POS_W  = $clog2(WINDOW_BITS);
	localparam int LIN_W  = POS_W - 5;
	localparam int DEPTH  = 2 ** (POS_W - 6);
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SPAN   = 2 ** POS_W;

	logic              started_q;
	logic [SEQ_W-1:0]  top_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [DEPTH-1:0]  vld_q;
	logic [WORD_W-1:0] mem [DEPTH];
	logic [LIN_W-1:0]  ks_q;
	logic [LIN_W-1:0]  ke_q;
	logic [LIN_W-1:0]  k_q;
	logic [LIN_W-1:0]  k_s1;
	logic [5:0]        s_lo_q;
	logic [5:0]        e_lo_q;
	logic              sweep_s1;
	logic              byp_s1;
	logic              zero_s1;
	logic [WORD_W-1:0] rd_s1;
	logic [WORD_W-1:0] byp_data_s1;

	logic [SEQ_W-1:0]  fwd_gap;
	logic [SEQ_W-1:0]  delta;
	logic [POS_W:0]    s_full;
	logic [POS_W-1:0]  s_pos;
	logic [POS_W-1:0]  e_pos;
	logic [POS_W:0]    e_lin;
	logic [ADDR_W-1:0] seq_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;
	logic              wr_en;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] word_s1;
	logic [WORD_W-1:0] bit_mask;
	logic [WORD_W-1:0] clr_mask;
	logic [5:0]        lo;
	logic [5:0]        hi;

	always_comb begin
		fwd_gap  = seq_q - top_q;
		delta    = top_q - seq_q;
		s_full   = {1'b0, top_q[POS_W-1:0]} + (POS_W+1)'(1);
		s_pos    = s_full[POS_W-1:0];
		e_pos    = seq_q[POS_W-1:0];
		// range of entering positions may wrap around the circular store
		e_lin    = (e_pos >= s_pos) ? {1'b0, e_pos} : {1'b0, e_pos} + (POS_W+1)'(SPAN);
		seq_addr = ADDR_W'(seq_q[SEQ_W-1:6] % DEPTH);
		rd_addr  = cmd.sweep_rd ? ADDR_W'(k_q % DEPTH) : seq_addr;
		word_s1  = byp_s1 ? byp_data_s1 : (zero_s1 ? '0 : rd_s1);
		bit_mask = WORD_W'(1) << seq_q[5:0];
		lo       = (k_s1 == ks_q) ? s_lo_q : 6'd0;
		hi       = (k_s1 == ke_q) ? e_lo_q : 6'd63;
		clr_mask = ({WORD_W{1'b1}} << lo) & ({WORD_W{1'b1}} >> (6'd63 - hi));

		wr_en   = 1'b0;
		wr_addr = seq_addr;
		wr_data = bit_mask;
		if (sweep_s1) begin
			wr_en   = 1'b1;
			wr_addr = ADDR_W'(k_s1 % DEPTH);
			wr_data = (word_s1 & ~clr_mask) | ((k_s1 == ke_q) ? bit_mask : '0);
		end else if (cmd.chk_mark) begin
			wr_en   = 1'b1;
			wr_data = word_s1 | bit_mask;
		end else if (cmd.init_all) begin
			wr_en   = 1'b1;
			wr_data = bit_mask;
		end

		sts.first      = ~started_q;
		sts.fwd        = seq_q > top_q;
		sts.far        = fwd_gap >= SEQ_W'(WINDOW_BITS);
		sts.old        = delta >= SEQ_W'(WINDOW_BITS);
		sts.sweep_last = (k_q == ke_q);
		sts.bit_set    = word_s1[seq_q[5:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			vld_q     <= '0;
			sweep_s1  <= 1'b0;
		end else begin
			sweep_s1 <= cmd.sweep_rd;
			if (cmd.take_top) begin
				started_q <= 1'b1;
			end
			if (cmd.init_all) begin
				vld_q <= DEPTH'(1) << seq_addr;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			seq_q <= seq_number;
		end
		if (cmd.take_top) begin
			top_q <= seq_q;
		end
		if (cmd.sweep_init) begin
			ks_q   <= LIN_W'(s_pos >> 6);
			ke_q   <= e_lin[POS_W:6];
			k_q    <= LIN_W'(s_pos >> 6);
			s_lo_q <= s_pos[5:0];
			e_lo_q <= e_pos[5:0];
		end else if (cmd.sweep_rd) begin
			k_q <= k_q + LIN_W'(1);
		end
		k_s1        <= k_q;
		zero_s1     <= ~vld_q[rd_addr];
		byp_s1      <= wr_en && (wr_addr == rd_addr);
		byp_data_s1 <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_s1 <= mem[rd_addr];
	end

endmodule

>>> rtl/arw_ctrl.sv
// controller: per-word sequencing and verdict output register
module arw_ctrl import arw_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [VERDICT_W-1:0] verdict,
	output arw_cmd_t             cmd,
	input  arw_sts_t             sts
);

	arw_state_t state_q;
	arw_state_t state_d;
	verdict_t   vd_q;
	verdict_t   vd_d;
	verdict_t   verdict_q;
	logic       out_vld_q;
	logic       out_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		vd_q <= vd_d;
		if (out_load) begin
			verdict_q <= vd_q;
		end
	end

	always_comb begin
		state_d  = state_q;
		vd_d     = vd_q;
		cmd      = '0;
		in_ready = 1'b0;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.first || (sts.fwd && sts.far)) begin
					cmd.init_all = 1'b1;
					cmd.take_top = 1'b1;
					vd_d         = VERDICT_ACCEPTED;
					state_d      = S_DONE;
				end else if (sts.fwd) begin
					cmd.sweep_init = 1'b1;
					cmd.take_top   = 1'b1;
					vd_d           = VERDICT_ACCEPTED;
					state_d        = S_SWEEP;
				end else if (sts.old) begin
					vd_d    = VERDICT_TOO_OLD;
					state_d = S_DONE;
				end else begin
					state_d = S_CHECK;
				end
			end
			S_SWEEP: begin
				cmd.sweep_rd = 1'b1;
				if (sts.sweep_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_CHECK: begin
				if (sts.bit_set) begin
					vd_d = VERDICT_DUPLICATE;
				end else begin
					cmd.chk_mark = 1'b1;
					vd_d         = VERDICT_ACCEPTED;
				end
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_vld_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_vld_q;
	assign verdict   = verdict_q;

endmodule

>>> rtl/anti_replay_window_check.sv
// Anti-replay window check: one verdict word (accepted, duplicate, too old) per sequence word.
// The seen bitmap is kept as a circular store of 2**ceil(log2(WINDOW_BITS)) bits in 64-bit
// memory words indexed by the low bits of the sequence number; each word has a valid flag
// that reset clears at once, so there is no clearing pass. One item is worked on at a time:
// the first item after reset, a forward jump of WINDOW_BITS or more, and a too-old item go
// from the decision state straight to the result; a check inside the window first reads
// its bitmap word and marks it unless its bit is set; a forward jump below WINDOW_BITS sweeps
// every 64-bit memory word that holds a position the jump passes over, then drains; at the
// default window such a jump can touch 17 words. A finished verdict waits in an output
// register while the next sequence word is accepted; the next verdict stalls until that
// register is taken.
module anti_replay_window_check import arw_pkg::*; #(
	parameter int WINDOW_BITS = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	arw_seq_if.sink       seq_in,
	arw_verdict_if.source verdict_out
);

	arw_cmd_t cmd;
	arw_sts_t sts;

	arw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (seq_in.valid),
		.in_ready  (seq_in.ready),
		.out_valid (verdict_out.valid),
		.out_ready (verdict_out.ready),
		.verdict   (verdict_out.verdict),
		.cmd       (cmd),
		.sts       (sts)
	);

	arw_dpath #(
		.WINDOW_BITS (WINDOW_BITS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.seq_number (seq_in.seq_number),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

>>> dv/tb_anti_replay_window_check.sv
// testbench for the anti-replay window check: predicts each verdict and checks it in order
`timescale 1ns / 1ps

module tb_anti_replay_window_check;
	import arw_pkg::*;

	localparam int WIN_BITS     = 1024;
	localparam int SEEN_BITS    = ((WIN_BITS + 63) / 64) * 64;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n;

	arw_seq_if     seq_ch ();
	arw_verdict_if verdict_ch ();

	anti_replay_window_check #(
		.WINDOW_BITS(WIN_BITS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.seq_in     (seq_ch),
		.verdict_out(verdict_ch)
	);

	// predicted window state
	logic                 win_started;
	logic [63:0]          win_top;
	logic [SEEN_BITS-1:0] win_seen;

	verdict_t    verdicts_due[$];
	logic [63:0] recent_seqs[$];
	verdict_t    want_verdict;

	int          err_count;
	int          words_sent;
	int          verdicts_seen;
	int          cycle_count;
	bit          src_idle_on;
	bit          sink_idle_on;
	int          hold_asks;
	int          hold_done;
	int          hold_left;

	always #5 clk = ~clk;

	function automatic verdict_t judge_sequence(input logic [63:0] s);
		logic [63:0] gap;
		if (!win_started) begin
			win_seen    = '0;
			win_top     = s;
			win_started = 1'b1;
			win_seen[0] = 1'b1;
			return VERDICT_ACCEPTED;
		end
		if (s > win_top) begin
			gap = s - win_top;
			if (gap >= 64'(WIN_BITS))
				win_seen = '0;
			else
				win_seen = win_seen << int'(gap);
			win_top     = s;
			win_seen[0] = 1'b1;
			return VERDICT_ACCEPTED;
		end
		gap = win_top - s;
		if (gap >= 64'(WIN_BITS))
			return VERDICT_TOO_OLD;
		if (win_seen[int'(gap)])
			return VERDICT_DUPLICATE;
		win_seen[int'(gap)] = 1'b1;
		return VERDICT_ACCEPTED;
	endfunction

	// mostly window-relative traffic, some replays and some full-range noise
	function automatic logic [63:0] pick_seq();
		int unsigned roll;
		logic [63:0] d;
		roll = $urandom_range(0, 99);
		if (!win_started)
			return {$urandom, $urandom};
		if (roll < 45) begin
			d = 64'($urandom_range(0, 1100));
			return (d <= win_top) ? win_top - d : win_top;
		end
		if (roll < 75) begin
			d = (roll < 70) ? 64'($urandom_range(1, 130)) : 64'($urandom_range(131, 1200));
			if (win_top > 64'hFFFF_FFFF_FFFF_FFFF - d)
				return win_top;
			return win_top + d;
		end
		if (roll < 87 && recent_seqs.size() > 0)
			return recent_seqs[$urandom_range(0, recent_seqs.size() - 1)];
		return {$urandom, $urandom};
	endfunction

	task automatic report_mismatch(input string what, input logic [1:0] got,
			input logic [1:0] want);
		$display("mismatch: %s, got %0d expected %0d (verdict %0d)", what, got, want,
			verdicts_seen);
		err_count++;
	endtask

	// send one word, starting and ending at a falling edge
	task automatic send_seq(input logic [63:0] s);
		int gaps;
		gaps = 0;
		while (src_idle_on && gaps < 12 && $urandom_range(0, 99) < 24)
			gaps++;
		if (gaps > 0) begin
			seq_ch.valid <= 1'b0;
			repeat (gaps) @(negedge clk);
		end
		seq_ch.valid      <= 1'b1;
		seq_ch.seq_number <= s;
		do @(posedge clk); while (seq_ch.ready !== 1'b1);
		verdicts_due.push_back(judge_sequence(s));
		recent_seqs.push_back(s);
		if (recent_seqs.size() > 16)
			void'(recent_seqs.pop_front());
		words_sent++;
		@(negedge clk);
	endtask

	task automatic test_window_basics();
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		send_seq(64'd0);
		send_seq(64'd0);
		send_seq(64'd5);
		send_seq(64'd3);
		send_seq(64'd3);
		send_seq(64'd2000);
		send_seq(64'd977);
		send_seq(64'd976);
		send_seq(64'd1936);
		send_seq(64'd2001);
		send_seq(64'd2064);
		send_seq(64'd2128);
		send_seq(64'd2193);
		send_seq(64'd1936);
		send_seq(64'd3217);
		send_seq(64'd2193);
		send_seq(64'd4240);
		send_seq(64'd3217);
	endtask

	task automatic test_receiver_stall();
		src_idle_on = 1'b0;
		@(posedge clk);
		hold_asks++;
		@(negedge clk);
		repeat (30)
			send_seq(pick_seq());
	endtask

	task automatic test_random_traffic(input int count, input bit idle);
		src_idle_on  = idle;
		sink_idle_on = idle;
		repeat (count)
			send_seq(pick_seq());
	endtask

	task automatic test_top_of_range();
		src_idle_on  = 1'b1;
		sink_idle_on = 1'b1;
		send_seq(64'hFFFF_FFFF_FFFF_FFFF);
		send_seq(64'hFFFF_FFFF_FFFF_FFFF);
		send_seq(64'hFFFF_FFFF_FFFF_FFFF - 64'd1023);
		send_seq(64'hFFFF_FFFF_FFFF_FFFF - 64'd1024);
		send_seq(64'd0);
		send_seq(64'h8000_0000_0000_0000);
	endtask

	// receiver side
	always @(negedge clk) begin
		if (hold_asks != hold_done) begin
			hold_done = hold_asks;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			verdict_ch.ready <= 1'b0;
		end else begin
			verdict_ch.ready <= !(sink_idle_on && $urandom_range(0, 99) < 24);
		end
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && verdict_ch.valid === 1'b1 && verdict_ch.ready === 1'b1) begin
			verdicts_seen++;
			if (verdicts_due.size() == 0) begin
				report_mismatch("verdict with none due", verdict_ch.verdict, 2'bxx);
			end else begin
				want_verdict = verdicts_due.pop_front();
				if (verdict_ch.verdict !== want_verdict)
					report_mismatch("wrong verdict", verdict_ch.verdict, want_verdict);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout with %0d verdicts outstanding", verdicts_due.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		arst_n                = 1'b0;
		seq_ch.valid          = 1'b0;
		seq_ch.seq_number     = '0;
		win_started           = 1'b0;
		win_top               = '0;
		win_seen              = '0;
		words_sent            = 0;
		src_idle_on           = 1'b0;
		sink_idle_on          = 1'b0;
		hold_asks             = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_window_basics();
		test_receiver_stall();
		test_random_traffic(420, 1'b1);
		test_random_traffic(150, 1'b0);
		test_top_of_range();

		seq_ch.valid <= 1'b0;
		sink_idle_on = 1'b1;
		while (verdicts_due.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d sequence words, checked %0d verdicts in order", words_sent,
			verdicts_seen);
		$display("window edges, forward jumps, replays, a long receiver stall, top of range");
		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", err_count);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

>>> filelist.f
rtl/arw_pkg.sv
rtl/arw_seq_if.sv
rtl/arw_verdict_if.sv
rtl/arw_dpath.sv
rtl/arw_ctrl.sv
rtl/anti_replay_window_check.sv
dv/tb_anti_replay_window_check.sv
